// File: src/slip_style_deframer_top_assert.svh
// Assertion macros for the deframer.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef SLIP_STYLE_DEFRAMER_TOP_ASSERT_SVH
`define SLIP_STYLE_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SDF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle implication");

`define SDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle implication");

`else

`define SDF_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define SDF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: src/slip_dfr_pkg.sv
`default_nettype none

package slip_dfr_pkg;

    // Framing bytes
    localparam logic [7:0] FRAME_END = 8'hC0;
    localparam logic [7:0] ESC       = 8'hDB;
    localparam logic [7:0] ESC_END   = 8'hDC;
    localparam logic [7:0] ESC_ESC   = 8'hDD;

    // Reset value of the frame length limit
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

    // Result kind
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_ESCAPE = 2'd1,
        ERR_LONG   = 2'd2
    } err_code_t;

endpackage

`default_nettype wire

// File: src/slip_style_deframer_top.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_in_byte[7:0]
// m_        out  m_valid/m_ready    m_out_byte[7:0], m_last, m_error_code[1:0]
// cfg_      in   cfg_wr_en          cfg_wr_data[15:0] (max_frame_len)
//
// One raw byte per cycle sustained while the result register is not stalled; a data
// byte goes through the input register and the hold stage into the result register.
// Throughput is set by the single decode stage, which updates the frame state.
// Reset (aresetn low, synchronous) clears frame state and both valid flags and
// sets max_frame_len to 4096.
// A stalled result register stops decode; s_ready drops once the input register is full.
`default_nettype none

`include "slip_style_deframer_top_assert.svh"

module slip_style_deframer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // raw byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    // decoded output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last,
    output logic [1:0]       m_error_code,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state
    logic        in_frame_reg,   in_frame_next;
    logic        esc_reg,        esc_next;
    logic        held_valid_reg, held_valid_next;
    logic [7:0]  held_byte_reg,  held_byte_next;
    logic [15:0] frame_len_reg,  frame_len_next;
    logic [15:0] max_len_reg;

    // Result register
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;
    slip_dfr_pkg::err_code_t out_err_reg;

    // Decode results
    logic                    emit;
    logic [7:0]              emit_byte;
    logic                    emit_last;
    slip_dfr_pkg::err_code_t emit_err;
    logic                    dec_valid;
    logic [7:0]              dec_byte;

    logic proc_go;

    // Decode advances when the result register is free or draining
    assign proc_go = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_go;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // Length limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= slip_dfr_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Byte decode and frame state update
    always_comb begin
        in_frame_next   = in_frame_reg;
        esc_next        = esc_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        frame_len_next  = frame_len_reg;
        emit            = 1'b0;
        emit_byte       = 8'd0;
        emit_last       = 1'b0;
        emit_err        = slip_dfr_pkg::ERR_NONE;
        dec_valid       = 1'b0;
        dec_byte        = in_byte_reg;

        priority if (!in_frame_reg) begin
            // hunting: only a delimiter opens a frame
            if (in_byte_reg == slip_dfr_pkg::FRAME_END) begin
                in_frame_next   = 1'b1;
                held_valid_next = 1'b0;
                held_byte_next  = 8'd0;
                frame_len_next  = 16'd0;
            end
        end else if (esc_reg) begin
            esc_next = 1'b0;
            priority if (in_byte_reg == slip_dfr_pkg::ESC_END) begin
                dec_valid = 1'b1;
                dec_byte  = slip_dfr_pkg::FRAME_END;
            end else if (in_byte_reg == slip_dfr_pkg::ESC_ESC) begin
                dec_valid = 1'b1;
                dec_byte  = slip_dfr_pkg::ESC;
            end else begin
                // bad escape; a delimiter here still opens the next frame
                emit            = 1'b1;
                emit_err        = slip_dfr_pkg::ERR_ESCAPE;
                in_frame_next   = (in_byte_reg == slip_dfr_pkg::FRAME_END);
                held_valid_next = 1'b0;
                held_byte_next  = 8'd0;
                frame_len_next  = 16'd0;
            end
        end else if (in_byte_reg == slip_dfr_pkg::FRAME_END) begin
            // close frame, flush held byte with last mark
            emit            = held_valid_reg;
            emit_byte       = held_byte_reg;
            emit_last       = 1'b1;
            held_valid_next = 1'b0;
            held_byte_next  = 8'd0;
            frame_len_next  = 16'd0;
        end else if (in_byte_reg == slip_dfr_pkg::ESC) begin
            esc_next = 1'b1;
        end else begin
            dec_valid = 1'b1;
        end

        // Length check, then push through the hold stage
        if (dec_valid) begin
            if (frame_len_reg >= max_len_reg) begin
                emit            = 1'b1;
                emit_byte       = 8'd0;
                emit_last       = 1'b0;
                emit_err        = slip_dfr_pkg::ERR_LONG;
                in_frame_next   = 1'b0;
                esc_next        = 1'b0;
                held_valid_next = 1'b0;
                held_byte_next  = 8'd0;
                frame_len_next  = 16'd0;
            end else begin
                emit            = held_valid_reg;
                emit_byte       = held_byte_reg;
                emit_last       = 1'b0;
                frame_len_next  = frame_len_reg + 16'd1;
                held_valid_next = 1'b1;
                held_byte_next  = dec_byte;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            esc_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            frame_len_reg  <= 16'd0;
        end else if (proc_go) begin
            in_frame_reg   <= in_frame_next;
            esc_reg        <= esc_next;
            held_valid_reg <= held_valid_next;
            frame_len_reg  <= frame_len_next;
        end
        if (proc_go) begin
            held_byte_reg <= held_byte_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc_go && emit) begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            out_err_reg  <= emit_err;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_last       = out_last_reg;
    assign m_error_code = out_err_reg;

    // Checks
    `SDF_ASSERT_IMPLY(a_abort_clean, aclk, aresetn,
        out_valid_reg && (out_err_reg != slip_dfr_pkg::ERR_NONE),
        (out_byte_reg == 8'd0) && !out_last_reg)
    `SDF_ASSERT_IMPLY(a_held_counted, aclk, aresetn, held_valid_reg, frame_len_reg != 16'd0)
    `SDF_ASSERT_IMPLY(a_esc_in_frame, aclk, aresetn, esc_reg, in_frame_reg)
    `SDF_ASSERT_NEXT(a_abort_drops_hold, aclk, aresetn,
        proc_go && emit && (emit_err != slip_dfr_pkg::ERR_NONE), !held_valid_reg)

endmodule

`default_nettype wire

// File: sim/tb_slip_style_deframer_top.sv
`default_nettype none

module tb_slip_style_deframer_top;

    typedef struct packed {
        logic [7:0]              data;
        logic                    last;
        slip_dfr_pkg::err_code_t code;
    } deframed_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic [1:0]  m_error_code;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    slip_style_deframer_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last),
        .m_error_code (m_error_code),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // raw bytes waiting to be offered, decoded results still owed by the block
    logic [7:0] raw_q[$];
    deframed_t  deframed_q[$];
    int         errors = 0;
    logic       s_took = 1'b0;

    // sender and receiver pacing
    int   gap_left = 0;
    int   burst_left = 0;
    logic tx_steady = 1'b0;
    logic rx_hold_arm = 1'b0;
    int   rx_hold_left = 0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;
    int   rx_tick = 0;

    // deframer state as predicted
    logic        hunt_n;
    logic        esc_seen;
    logic        held_ok;
    logic [7:0]  held;
    logic [15:0] frame_len;
    logic [15:0] max_len;

    function automatic void put_raw(input logic [7:0] b);
        raw_q = {raw_q, b};
    endfunction

    function automatic void restart_frame(input logic open);
        hunt_n    = open;
        esc_seen  = 1'b0;
        held_ok   = 1'b0;
        held      = 8'h00;
        frame_len = 16'd0;
    endfunction

    // length check, then the held byte goes out and the new one takes its place
    function automatic bit take_byte(input logic [7:0] d, output deframed_t r);
        bit got;
        r = '0;
        if (frame_len >= max_len) begin
            restart_frame(1'b0);
            r.code = slip_dfr_pkg::ERR_LONG;
            return 1'b1;
        end
        frame_len = frame_len + 16'd1;
        got    = held_ok;
        r.data = held;
        r.code = slip_dfr_pkg::ERR_NONE;
        held    = d;
        held_ok = 1'b1;
        return got;
    endfunction

    function automatic bit deframe(input logic [7:0] b, output deframed_t r);
        bit got;
        r = '0;
        if (!hunt_n) begin
            if (b == slip_dfr_pkg::FRAME_END)
                restart_frame(1'b1);
            return 1'b0;
        end
        if (esc_seen) begin
            esc_seen = 1'b0;
            if (b == slip_dfr_pkg::ESC_END)
                return take_byte(slip_dfr_pkg::FRAME_END, r);
            if (b == slip_dfr_pkg::ESC_ESC)
                return take_byte(slip_dfr_pkg::ESC, r);
            // bad escape; a delimiter here still opens the next frame
            restart_frame(b == slip_dfr_pkg::FRAME_END);
            r.code = slip_dfr_pkg::ERR_ESCAPE;
            return 1'b1;
        end
        if (b == slip_dfr_pkg::FRAME_END) begin
            got    = held_ok;
            r.data = held;
            r.last = 1'b1;
            r.code = slip_dfr_pkg::ERR_NONE;
            restart_frame(1'b1);
            return got;
        end
        if (b == slip_dfr_pkg::ESC) begin
            esc_seen = 1'b1;
            return 1'b0;
        end
        return take_byte(b, r);
    endfunction

    // input acceptance feeds the predictor; output transactions are checked in order
    always @(posedge aclk) begin
        deframed_t r;
        deframed_t w;
        s_took = aresetn && s_valid && s_ready;
        if (s_took) begin
            if (deframe(s_in_byte, r))
                deframed_q = {deframed_q, r};
        end
        if (aresetn && m_valid && m_ready) begin
            if (deframed_q.size() == 0) begin
                $display("%0t: unexpected result byte %h last %b code %0d", $time,
                         m_out_byte, m_last, m_error_code);
                errors++;
            end else begin
                w = deframed_q.pop_front();
                if (m_out_byte !== w.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time, w.data, m_out_byte);
                    errors++;
                end
                if (m_last !== w.last) begin
                    $display("%0t: last expected %b actual %b", $time, w.last, m_last);
                    errors++;
                end
                if (m_error_code !== w.code) begin
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             w.code, m_error_code);
                    errors++;
                end
            end
        end
    end

    // sender: bursts of random length with random gaps
    always @(negedge aclk) begin
        logic       nv;
        logic [7:0] nb;
        nv = s_valid;
        nb = s_in_byte;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (!s_valid || s_took) begin
            nv = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (raw_q.size() != 0) begin
                nv = 1'b1;
                nb = raw_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 32);
                    if (tx_steady || $urandom_range(0, 3) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
        s_valid   <= nv;
        s_in_byte <= nb;
    end

    // receiver: stall pattern that changes mode now and then, plus one long hold
    always @(negedge aclk) begin
        logic rdy;
        rdy = 1'b0;
        if (aresetn) begin
            if (rx_hold_arm) begin
                rx_hold_left = 120;
                rx_hold_arm  = 1'b0;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(16, 96);
                end else begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (rx_tick % 4) == 0;
                    default: rdy = $urandom_range(0, 7) != 0;
                endcase
                rx_tick++;
            end
        end
        m_ready <= rdy;
    end

    task automatic wait_drained();
        while (raw_q.size() != 0 || s_valid || deframed_q.size() != 0)
            @(posedge aclk);
        // bytes that give no result may still sit in the pipeline
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        max_len = v;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return slip_dfr_pkg::FRAME_END;
            1: return slip_dfr_pkg::ESC;
            2: return slip_dfr_pkg::ESC_END;
            3: return slip_dfr_pkg::ESC_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed stuffed frames, the rest noise and broken escapes
    task automatic random_phase(input int budget);
        int         count;
        int         len;
        int         lim;
        logic [7:0] b;
        count = 1;
        put_raw(slip_dfr_pkg::FRAME_END);
        while (count < budget) begin
            if ($urandom_range(0, 99) < 82) begin
                lim = max_len;
                case ($urandom_range(0, 7))
                    0: len = 0;
                    1: len = (lim <= 64) ? lim + $urandom_range(0, 2) - 1 : 1;
                    2: len = $urandom_range(11, 40);
                    default: len = $urandom_range(1, 10);
                endcase
                if (len < 0)
                    len = 0;
                for (int i = 0; i < len; i++) begin
                    b = pick_byte();
                    if (b == slip_dfr_pkg::FRAME_END) begin
                        put_raw(slip_dfr_pkg::ESC);
                        put_raw(slip_dfr_pkg::ESC_END);
                        count += 2;
                    end else if (b == slip_dfr_pkg::ESC) begin
                        put_raw(slip_dfr_pkg::ESC);
                        put_raw(slip_dfr_pkg::ESC_ESC);
                        count += 2;
                    end else begin
                        put_raw(b);
                        count++;
                    end
                end
                put_raw(slip_dfr_pkg::FRAME_END);
                count++;
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == slip_dfr_pkg::ESC_END || b == slip_dfr_pkg::ESC_ESC);
                        put_raw(slip_dfr_pkg::ESC);
                        put_raw(b);
                        count += 2;
                    end
                    1: begin
                        put_raw(slip_dfr_pkg::ESC);
                        put_raw(slip_dfr_pkg::FRAME_END);
                        count += 2;
                    end
                    default: begin
                        len = $urandom_range(1, 3);
                        for (int i = 0; i < len; i++)
                            put_raw(pick_byte());
                        count += len;
                    end
                endcase
            end
        end
    endtask

    initial begin
        restart_frame(1'b0);
        max_len = slip_dfr_pkg::MAX_LEN_RESET;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset limit: hunting, escapes, empty frame, bad escapes
        raw_q = {raw_q, 8'h55, slip_dfr_pkg::ESC, slip_dfr_pkg::FRAME_END, 8'h00, 8'hFF,
                 slip_dfr_pkg::ESC, slip_dfr_pkg::ESC_END, slip_dfr_pkg::ESC,
                 slip_dfr_pkg::ESC_ESC, slip_dfr_pkg::FRAME_END, slip_dfr_pkg::FRAME_END,
                 8'h7E, slip_dfr_pkg::ESC, 8'h41, 8'h12, slip_dfr_pkg::FRAME_END,
                 slip_dfr_pkg::ESC, slip_dfr_pkg::FRAME_END, 8'h5A, slip_dfr_pkg::FRAME_END};
        wait_drained();

        // frame exactly at the limit, then one byte over
        write_limit(16'd3);
        raw_q = {raw_q, 8'h01, 8'h02, 8'h03, slip_dfr_pkg::FRAME_END, 8'h01, 8'h02, 8'h03,
                 8'h04, slip_dfr_pkg::FRAME_END};
        wait_drained();
        write_limit(16'd1);
        raw_q = {raw_q, 8'hA5, slip_dfr_pkg::FRAME_END, 8'hA5, 8'hB6, slip_dfr_pkg::FRAME_END};
        wait_drained();
        // zero limit aborts on the first decoded byte
        write_limit(16'd0);
        raw_q = {raw_q, slip_dfr_pkg::ESC, slip_dfr_pkg::ESC_END, slip_dfr_pkg::FRAME_END,
                 8'h77, slip_dfr_pkg::FRAME_END};
        wait_drained();

        write_limit(16'hFFFF);
        random_phase(200);
        wait_drained();

        write_limit(16'd1);
        random_phase(150);
        wait_drained();

        write_limit(16'($urandom_range(2, 16)));
        random_phase(200);
        wait_drained();

        // long receiver hold while the sender keeps pushing
        write_limit(slip_dfr_pkg::MAX_LEN_RESET);
        tx_steady = 1'b1;
        random_phase(250);
        repeat (20) @(posedge aclk);
        rx_hold_arm = 1'b1;
        wait_drained();
        tx_steady = 1'b0;

        write_limit(16'($urandom_range(17, 65534)));
        random_phase(200);
        wait_drained();

        write_limit(16'($urandom_range(1, 8)));
        random_phase(150);
        wait_drained();

        if (errors == 0)
            $display("tb_slip_style_deframer_top: PASS");
        else
            $display("tb_slip_style_deframer_top: FAIL");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_slip_style_deframer_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
